FILE: rtl/core/wtf8s_pkg.sv
package wtf8s_pkg;

  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned BufDepth = 7;

  localparam logic [7:0] ContLo = 8'h80;
  localparam logic [7:0] ContHi = 8'hbf;
  localparam logic [23:0] FffdBytes = 24'hbdbfef;
  localparam logic [20:0] HiSurBase = 21'h00d800;
  localparam logic [20:0] LoSurBase = 21'h00dc00;
  localparam logic [20:0] SuppBase = 21'h010000;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       pass;
  } q_word_t;

  typedef struct packed {
    logic [1:0]  cont;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [20:0] part;
    logic        hs;
    logic [9:0]  hsb;
    logic [1:0]  lac;
  } dec_t;

  localparam dec_t DecReset = '{cont: 2'd0, lo: ContLo, hi: ContHi, part: 21'd0,
                                hs: 1'b0, hsb: 10'd0, lac: 2'd0};

  typedef struct packed {
    logic [3:0][7:0] ob;
    logic [2:0]      n;
  } cp_bytes_t;

  typedef struct packed {
    dec_t            st;
    logic [5:0][7:0] ob;
    logic [2:0]      n;
  } dec_res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FIRST,
    BK_WORK,
    BK_END,
    BK_FIN
  } bk_state_e;

  function automatic cp_bytes_t enc_cp(logic [20:0] cp);
    cp_bytes_t r;
    r.ob = '0;
    if (cp <= 21'h0007ff) begin
      r.ob[0] = {3'b110, cp[10:6]};
      r.ob[1] = {2'b10, cp[5:0]};
      r.n = 3'd2;
    end else if (cp <= 21'h00ffff) begin
      r.ob[0] = {4'b1110, cp[15:12]};
      r.ob[1] = {2'b10, cp[11:6]};
      r.ob[2] = {2'b10, cp[5:0]};
      r.n = 3'd3;
    end else begin
      r.ob[0] = {5'b11110, cp[20:18]};
      r.ob[1] = {2'b10, cp[17:12]};
      r.ob[2] = {2'b10, cp[11:6]};
      r.ob[3] = {2'b10, cp[5:0]};
      r.n = 3'd4;
    end
    return r;
  endfunction

  function automatic dec_res_t decode(dec_t s, logic [7:0] b);
    dec_res_t r;
    cp_bytes_t e;
    logic [20:0] p;
    logic [1:0] cnt;
    logic fall;
    logic pre;
    logic [2:0][7:0] lob;
    logic [2:0] ln;
    r.st = s;
    r.ob = '0;
    r.n = 3'd0;
    fall = 1'b1;
    pre = 1'b0;
    lob = '0;
    ln = 3'd0;
    p = {s.part[14:0], b[5:0]};
    cnt = s.cont - 2'd1;
    if (s.cont != 2'd0) begin
      if (b >= s.lo && b <= s.hi) begin
        fall = 1'b0;
        r.st.part = p;
        r.st.cont = cnt;
        r.st.lo = ContLo;
        r.st.hi = ContHi;
        if (cnt == 2'd0) begin
          r.st.part = 21'd0;
          if (p >= HiSurBase && p < LoSurBase) begin
            r.st.hs = 1'b1;
            r.st.hsb = p[9:0];
            r.st.lac = 2'd0;
          end else begin
            e = enc_cp(p);
            r.ob = {16'h0, e.ob};
            r.n = e.n;
          end
        end
      end else begin
        pre = 1'b1;
      end
    end
    if (fall) begin
      r.st.cont = 2'd0;
      r.st.lo = ContLo;
      r.st.hi = ContHi;
      r.st.part = 21'd0;
      if (b < 8'h80) begin
        lob[0] = b;
        ln = 3'd1;
      end else if (b >= 8'hc2 && b <= 8'hdf) begin
        r.st.part = {16'd0, b[4:0]};
        r.st.cont = 2'd1;
      end else if (b >= 8'he0 && b <= 8'hef) begin
        r.st.part = {17'd0, b[3:0]};
        r.st.cont = 2'd2;
        r.st.lo = (b == 8'he0) ? 8'ha0 : ContLo;
      end else if (b >= 8'hf0 && b <= 8'hf4) begin
        r.st.part = {18'd0, b[2:0]};
        r.st.cont = 2'd3;
        r.st.lo = (b == 8'hf0) ? 8'h90 : ContLo;
        r.st.hi = (b == 8'hf4) ? 8'h8f : ContHi;
      end else begin
        lob = FffdBytes;
        ln = 3'd3;
      end
      if (pre) begin
        r.ob = {lob, FffdBytes};
        r.n = 3'd3 + ln;
      end else begin
        r.ob = {24'h0, lob};
        r.n = ln;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/wtf8_sanitizer.sv
// channel | dir | handshake              | payload
// in      | in  | in_valid_i/in_stall_o  | in_byte_i, last_byte_i
// out     | out | out_valid_o/out_stall_i| out_byte_o, run_end_o, string_end_o
// cfg     | in  | cfg_valid_i/cfg_ready_o| cfg_data_i (detect_symbols)
//
// a byte passes through the decode sequencer (pop, decode, end check, finish) and its
// output bytes drain from the output buffer; a broken surrogate pair replays up to
// three held bytes, one per cycle while the output buffer has room
// the input queue takes a word every cycle until full, so in_stall_o follows it
// reset is asynchronous and returns every string state, detect_symbols to 1
// out holds a word under out_stall_i; the output register frees in the same cycle
module wtf8_sanitizer import wtf8s_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o,
  output logic       string_end_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  logic detect_q;
  logic push, full, pop, qvalid;
  q_word_t wword, rword;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      detect_q <= cfg_data_i;
    end
  end

  wtf8s_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .detect_i   (detect_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .last_byte_i(last_byte_i),
    .push_o     (push),
    .word_o     (wword),
    .full_i     (full)
  );

  wtf8s_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .word_i (wword),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(qvalid),
    .word_o (rword)
  );

  wtf8s_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (qvalid),
    .word_i      (rword),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_end_o   (run_end_o),
    .string_end_o(string_end_o)
  );

endmodule

FILE: rtl/core/wtf8s_front.sv
module wtf8s_front import wtf8s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       detect_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  output logic       push_o,
  output q_word_t    word_o,
  input  logic       full_i
);

  logic start_q, start_d;
  logic pass_q, pass_d;
  logic is_sym, pass_now, acc;

  assign in_stall_o = full_i;
  assign acc = in_valid_i && !full_i;

  always_comb begin
    is_sym = detect_i && (in_byte_i == 8'h80 || in_byte_i == 8'h81 ||
                          in_byte_i == 8'h82 || in_byte_i == 8'hff);
    pass_now = start_q ? is_sym : pass_q;
    start_d = start_q;
    pass_d = pass_q;
    if (acc) begin
      start_d = last_byte_i;
      pass_d = last_byte_i ? 1'b0 : pass_now;
    end
  end

  assign push_o = acc;
  assign word_o = '{b: in_byte_i, last: last_byte_i, pass: pass_now};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      pass_q <= 1'b0;
    end else begin
      start_q <= start_d;
      pass_q <= pass_d;
    end
  end

endmodule

FILE: rtl/core/wtf8s_fifo.sv
module wtf8s_fifo import wtf8s_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_word_t word_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output q_word_t word_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);

  q_word_t mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o = (cnt_q == CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign word_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/wtf8s_back.sv
module wtf8s_back import wtf8s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  q_word_t    word_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o,
  output logic       string_end_o
);

  bk_state_e state_q, state_d;
  q_word_t cur_q, cur_d;
  dec_t dec_q, dec_d;
  logic [1:0][7:0] la_q, la_d;
  logic [2:0][7:0] wl_q, wl_d;
  logic [1:0] wl_n_q, wl_n_d, wl_i_q, wl_i_d;
  logic [BufDepth-1:0][7:0] buf_q, buf_d;
  logic [2:0] bn_q, bn_d, base;
  logic ov_q, ov_d, re_q, re_d, se_q, se_d;
  logic [7:0] ob_q, ob_d;
  logic [5:0][7:0] app;
  logic [2:0] app_n;
  logic out_free, drain, fin_emit, room, ok;
  dec_res_t r;
  cp_bytes_t e;
  logic [9:0] lo_bits;

  always_comb begin
    state_d = state_q;
    cur_d = cur_q;
    dec_d = dec_q;
    la_d = la_q;
    wl_d = wl_q;
    wl_n_d = wl_n_q;
    wl_i_d = wl_i_q;
    app = '0;
    app_n = 3'd0;
    pop_o = 1'b0;
    ok = 1'b0;
    r = '0;
    e = '0;
    lo_bits = {la_q[1][3:0], cur_q.b[5:0]};
    out_free = !ov_q || !out_stall_i;
    fin_emit = (state_q == BK_FIN) && (bn_q == 3'd1);
    drain = out_free && ((bn_q >= 3'd2) || fin_emit);
    room = (bn_q <= 3'd1);

    case (state_q)
      BK_IDLE: begin
        pop_o = valid_i;
        if (valid_i) begin
          cur_d = word_i;
          state_d = BK_FIRST;
        end
      end
      BK_FIRST: begin
        if (room) begin
          state_d = BK_END;
          if (cur_q.pass) begin
            app[0] = cur_q.b;
            app_n = 3'd1;
          end else if (!dec_q.hs) begin
            r = decode(dec_q, cur_q.b);
            dec_d = r.st;
            app = r.ob;
            app_n = r.n;
          end else begin
            case (dec_q.lac)
              2'd0: ok = (cur_q.b == 8'hed);
              2'd1: ok = (cur_q.b >= 8'hb0 && cur_q.b <= 8'hbf);
              default: ok = (cur_q.b >= 8'h80 && cur_q.b <= 8'hbf);
            endcase
            if (ok && dec_q.lac < 2'd2) begin
              la_d[dec_q.lac[0]] = cur_q.b;
              dec_d.lac = dec_q.lac + 2'd1;
            end else if (ok) begin
              e = enc_cp(SuppBase + {1'b0, dec_q.hsb, 10'd0} + {11'd0, lo_bits});
              app = {16'h0, e.ob};
              app_n = e.n;
              dec_d.hs = 1'b0;
              dec_d.lac = 2'd0;
            end else begin
              e = enc_cp({5'd0, 6'b110110, dec_q.hsb});
              app = {16'h0, e.ob};
              app_n = e.n;
              dec_d.hs = 1'b0;
              dec_d.lac = 2'd0;
              wl_d = {cur_q.b, la_q[1], la_q[0]};
              if (dec_q.lac == 2'd0) begin
                wl_d[0] = cur_q.b;
              end else if (dec_q.lac == 2'd1) begin
                wl_d[1] = cur_q.b;
              end
              wl_n_d = dec_q.lac + 2'd1;
              wl_i_d = 2'd0;
              state_d = BK_WORK;
            end
          end
        end
      end
      BK_WORK: begin
        if (room) begin
          r = decode(dec_q, wl_q[wl_i_q]);
          dec_d = r.st;
          app = r.ob;
          app_n = r.n;
          wl_i_d = wl_i_q + 2'd1;
          if (wl_i_d == wl_n_q) begin
            state_d = BK_END;
          end
        end
      end
      BK_END: begin
        if (room) begin
          if (!cur_q.last || cur_q.pass) begin
            state_d = BK_FIN;
          end else if (dec_q.hs) begin
            e = enc_cp({5'd0, 6'b110110, dec_q.hsb});
            app = {16'h0, e.ob};
            app_n = e.n;
            dec_d.hs = 1'b0;
            dec_d.lac = 2'd0;
            if (dec_q.lac != 2'd0) begin
              wl_d = {8'h00, la_q[1], la_q[0]};
              wl_n_d = dec_q.lac;
              wl_i_d = 2'd0;
              state_d = BK_WORK;
            end
          end else if (dec_q.cont != 2'd0) begin
            app = {24'h0, FffdBytes};
            app_n = 3'd3;
            dec_d = DecReset;
            state_d = BK_FIN;
          end else begin
            state_d = BK_FIN;
          end
        end
      end
      BK_FIN: begin
        if (bn_q == 3'd0) begin
          state_d = BK_IDLE;
          if (cur_q.last) begin
            dec_d = DecReset;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase

    buf_d = buf_q;
    base = bn_q;
    if (drain) begin
      buf_d = {8'h00, buf_q[BufDepth-1:1]};
      base = bn_q - 3'd1;
    end
    for (int j = 0; j < BufDepth; j++) begin
      if (j >= int'(base) && j < int'(base) + 6) begin
        buf_d[j] = app[3'(j - int'(base))];
      end
    end
    bn_d = base + app_n;

    ov_d = ov_q;
    ob_d = ob_q;
    re_d = re_q;
    se_d = se_q;
    if (drain) begin
      ov_d = 1'b1;
      ob_d = buf_q[0];
      re_d = fin_emit;
      se_d = fin_emit && cur_q.last;
    end else if (out_free) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      dec_q <= DecReset;
      bn_q <= 3'd0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dec_q <= dec_d;
      bn_q <= bn_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    la_q <= la_d;
    wl_q <= wl_d;
    wl_n_q <= wl_n_d;
    wl_i_q <= wl_i_d;
    buf_q <= buf_d;
    ob_q <= ob_d;
    re_q <= re_d;
    se_q <= se_d;
  end

  assign out_valid_o = ov_q;
  assign out_byte_o = ob_q;
  assign run_end_o = re_q;
  assign string_end_o = se_q;

endmodule

FILE: rtl/core/wtf8s_checker.sv
module wtf8s_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input logic [7:0] out_byte_i,
  input logic       run_end_i,
  input logic       string_end_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_byte_i))
    else $error("stalled output word changed");

  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && string_end_i |-> run_end_i)
    else $error("string end without run end");

  a_rst: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind wtf8_sanitizer wtf8s_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_i  (out_byte_o),
  .run_end_i   (run_end_o),
  .string_end_i(string_end_o)
);
